>>> src/key_press_classifier_fifo_unit_macros.svh
// Assertion macros used by the checker file of the key press classifier.
// No dependencies; the including scope must provide clock and reset.
`ifndef KEY_PRESS_CLASSIFIER_FIFO_UNIT_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_FIFO_UNIT_MACROS_SVH

// Checked only while the block is out of reset.
`define KPCF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("key press classifier check failed");

// Checked on every edge, reset included.
`define KPCF_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("key press classifier reset check failed");

`endif

>>> src/kpcf_pkg.sv
// Package for the key press classifier: widths, reset values and codes.
// No dependencies.
package kpcf_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int TICKS_W = 8;

   localparam logic [TICKS_W-1:0] LONG_TICKS_RESET = 8'd50;

   // Button phases.
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_CONFIRM = 2'd1;
   localparam logic [1:0] PH_HELD    = 2'd2;
   localparam logic [1:0] PH_RELEASE = 2'd3;

   // Event kinds.
   localparam logic EV_SHORT = 1'b0;
   localparam logic EV_LONG  = 1'b1;

   // Commands.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_POP  = 1'b1;

endpackage

>>> src/kpcf_ifs.sv
// Valid/ready channel interfaces of the key press classifier.
// No dependencies.
interface kpcf_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic button_down;

   modport source (output valid, output cmd, output button_down, input ready);
   modport sink (input valid, input cmd, input button_down, output ready);
endinterface

interface kpcf_rsp_if;
   logic valid;
   logic ready;
   logic event_valid;
   logic event_code;
   logic pending;

   modport source (output valid, output event_valid, output event_code, output pending,
                   input ready);
   modport sink (input valid, input event_valid, input event_code, input pending,
                 output ready);
endinterface

>>> src/key_press_classifier_fifo_unit.sv
// Debounced button short/long press classifier with an event ring.
// Depends on kpcf_pkg and the channel interfaces in kpcf_ifs.sv.
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    cmd, button_down
//   rsp_ch    out        valid/ready    event_valid, event_code, pending
//   csr       in         csr_we         csr_wdata (long press threshold)
//
// Each item updates the phase machine and the ring pointers at the edge where it is
// accepted, and its result is loaded into the output register at that same edge.
// One item per cycle is sustained; the output register stalls input only when a result
// waits and rsp_ch.ready is low. The ring head is held in a registered read of the event
// memory. Reset is synchronous and needs no clearing pass.
module key_press_classifier_fifo_unit #(
   parameter int QUEUE_DEPTH = kpcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   kpcf_req_if.sink                     req_ch,
   kpcf_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic [kpcf_pkg::TICKS_W-1:0] csr_wdata
);
   import kpcf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [TICKS_W-1:0] long_ticks_ff;
   logic [1:0]         phase_ff, phase_in;
   logic [TICKS_W-1:0] hold_ff, hold_in;
   logic               long_rep_ff, long_rep_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_next, wr_next;
   logic               event_mem [QUEUE_DEPTH];
   logic               head_ff;
   logic               accept;
   logic               tick;
   logic               pop;
   logic               push_req;
   logic               push;
   logic               push_code;
   logic               below_limit;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               ev_valid_ff;
   logic               ev_code_ff;
   logic               pending_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign tick         = accept && (req_ch.cmd == CMD_TICK);
   assign below_limit  = hold_ff < long_ticks_ff;

   assign rd_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign wr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;

   // Phase machine; it only moves on an accepted scan tick.
   always_comb begin
      phase_in    = phase_ff;
      hold_in     = hold_ff;
      long_rep_in = long_rep_ff;
      push_req    = 1'b0;
      push_code   = EV_SHORT;
      if (tick) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_ch.button_down) phase_in = PH_CONFIRM;
            end
            PH_CONFIRM: begin
               if (req_ch.button_down) begin
                  phase_in = PH_HELD;
                  hold_in  = '0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_HELD: begin
               if (req_ch.button_down) begin
                  if (below_limit) begin
                     hold_in = hold_ff + 1'b1;
                  end else if (!long_rep_ff) begin
                     push_req    = 1'b1;
                     push_code   = EV_LONG;
                     long_rep_in = 1'b1;
                  end
               end else begin
                  phase_in    = PH_RELEASE;
                  long_rep_in = 1'b0;
               end
            end
            default: begin
               if (req_ch.button_down) begin
                  phase_in = PH_HELD;
               end else begin
                  push_req = below_limit;
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
   end

   // The ring keeps one slot free, so a push into the last free slot is dropped.
   assign push      = push_req && (wr_next != rd_ptr_ff);
   assign pop       = accept && (req_ch.cmd == CMD_POP) && (rd_ptr_ff != wr_ptr_ff);
   assign wr_ptr_in = push ? wr_next : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_next : rd_ptr_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff <= LONG_TICKS_RESET;
         phase_ff      <= PH_IDLE;
         hold_ff       <= '0;
         long_rep_ff   <= 1'b0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) long_ticks_ff <= csr_wdata;
         phase_ff     <= phase_in;
         hold_ff      <= hold_in;
         long_rep_ff  <= long_rep_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Event memory. head_ff always mirrors the entry at the read pointer; a write to that
   // entry in the same cycle is forwarded.
   always_ff @(posedge clock) begin
      if (push) event_mem[wr_ptr_ff] <= push_code;
      head_ff <= (push && (wr_ptr_ff == rd_ptr_in)) ? push_code : event_mem[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ev_valid_ff <= pop;
         ev_code_ff  <= pop ? head_ff : EV_SHORT;
         pending_ff  <= rd_ptr_in != wr_ptr_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.event_valid = ev_valid_ff;
   assign rsp_ch.event_code  = ev_code_ff;
   assign rsp_ch.pending     = pending_ff;

endmodule

>>> src/kpcf_checker.sv
// Port-level checks for the key press classifier and the bind that attaches them.
// Depends on key_press_classifier_fifo_unit_macros.svh and the top level.
`include "key_press_classifier_fifo_unit_macros.svh"

module kpcf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_event_valid,
   input logic rsp_event_code,
   input logic rsp_pending
);

   // Each accepted item shows its result on the next cycle.
   `KPCF_ASSERT(a_result_follows, (req_valid && req_ready) |=> rsp_valid)

   // A waiting result blocks new items, so it cannot be overwritten.
   `KPCF_ASSERT(a_no_overrun, (rsp_valid && !rsp_ready) |-> !req_ready)

   // A stalled result keeps its payload.
   `KPCF_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid
      && $stable(rsp_event_valid) && $stable(rsp_event_code) && $stable(rsp_pending)))

   // Nothing is offered right after reset.
   `KPCF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind key_press_classifier_fifo_unit kpcf_checker u_kpcf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_event_valid (rsp_ch.event_valid),
   .rsp_event_code  (rsp_ch.event_code),
   .rsp_pending     (rsp_ch.pending)
);

>>> tb/key_press_classifier_fifo_unit_tb.sv
// Self-checking testbench for key_press_classifier_fifo_unit: button scan ticks and event pops.
// Depends on kpcf_pkg and the channel interfaces in kpcf_ifs.sv; results are checked against
// a behavioral copy of the debounce machine and its event ring.
module key_press_classifier_fifo_unit_tb;
   import kpcf_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
   localparam int ITEM_TARGET = 1150;
   localparam int N_DIRECTED = 32;

   typedef struct packed {
      logic event_valid;
      logic event_code;
      logic pending;
   } key_result_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      logic           cmd;
      logic           button;
      logic           pinned;
      key_result_type want;
      logic [7:0]     value;
   } stim_row_type;

   // Pinned results are written as {event_valid, event_code, pending}.
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{ROW_ITEM, CMD_POP,  1'b1, 1'b1, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b1, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b0, 1'b1, 3'b000, 8'd0},
      '{ROW_CFG,  CMD_TICK, 1'b0, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b1, 3'b001, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b0, 1'b1, 3'b001, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b1, 3'b001, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b1, 3'b001, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b0, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b0, 1'b1, 3'b001, 8'd0},
      '{ROW_ITEM, CMD_POP,  1'b0, 1'b1, 3'b111, 8'd0},
      '{ROW_ITEM, CMD_POP,  1'b1, 1'b1, 3'b110, 8'd0},
      '{ROW_ITEM, CMD_POP,  1'b0, 1'b1, 3'b000, 8'd0},
      '{ROW_CFG,  CMD_TICK, 1'b0, 1'b0, 3'b000, 8'd255},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b0, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b0, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_POP,  1'b1, 1'b1, 3'b100, 8'd0},
      '{ROW_CFG,  CMD_TICK, 1'b0, 1'b0, 3'b000, 8'd2},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_CFG,  CMD_TICK, 1'b0, 1'b0, 3'b000, 8'd5},
      '{ROW_ITEM, CMD_TICK, 1'b1, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b0, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_TICK, 1'b0, 1'b0, 3'b000, 8'd0},
      '{ROW_ITEM, CMD_POP,  1'b0, 1'b1, 3'b100, 8'd0}
   };

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [TICKS_W-1:0] csr_wdata;

   // Sideband that travels with each item: a typed result replaces the prediction.
   logic               row_pinned;
   key_result_type     row_result;

   kpcf_req_if req_ch ();
   kpcf_rsp_if rsp_ch ();

   key_press_classifier_fifo_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Behavioral copy of the press classifier.
   logic [1:0]         btn_phase;
   logic [TICKS_W-1:0] hold_ticks;
   logic               long_flagged;
   logic [TICKS_W-1:0] long_threshold;
   int                 head_ptr;
   int                 tail_ptr;
   logic               press_log [DEPTH];

   key_result_type expected_results [$];
   int             items_sent;
   int             results_seen;
   int             mismatch_count;

   bit          no_idle;
   int          pop_pct;
   int          cur_thr;
   int          long_budget;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("key_press_classifier_fifo_unit test failed");
      $finish;
   end

   task automatic note_mismatch(string msg);
      $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   function automatic void log_event(logic code);
      // One slot stays empty, so a full ring drops the new event.
      if ((tail_ptr + 1) % DEPTH != head_ptr) begin
         press_log[tail_ptr] = code;
         tail_ptr = (tail_ptr + 1) % DEPTH;
      end
   endfunction

   function automatic key_result_type classify_step(logic cmd, logic pressed);
      key_result_type r;
      r = '0;
      if (cmd == CMD_POP) begin
         if (head_ptr != tail_ptr) begin
            r.event_valid = 1'b1;
            r.event_code = press_log[head_ptr];
            head_ptr = (head_ptr + 1) % DEPTH;
         end
      end else begin
         case (btn_phase)
            PH_IDLE: begin
               if (pressed) btn_phase = PH_CONFIRM;
            end
            PH_CONFIRM: begin
               if (pressed) begin
                  btn_phase = PH_HELD;
                  hold_ticks = '0;
               end else begin
                  btn_phase = PH_IDLE;
               end
            end
            PH_HELD: begin
               if (pressed) begin
                  if (hold_ticks < long_threshold) begin
                     hold_ticks = hold_ticks + 1'b1;
                  end else if (!long_flagged) begin
                     log_event(EV_LONG);
                     long_flagged = 1'b1;
                  end
               end else begin
                  btn_phase = PH_RELEASE;
                  long_flagged = 1'b0;
               end
            end
            default: begin
               // A press here is contact bounce; the hold count carries over.
               if (pressed) begin
                  btn_phase = PH_HELD;
               end else begin
                  if (hold_ticks < long_threshold) log_event(EV_SHORT);
                  btn_phase = PH_IDLE;
               end
            end
         endcase
      end
      r.pending = (head_ptr != tail_ptr);
      return r;
   endfunction

   always @(posedge clock) begin
      key_result_type got;
      key_result_type want;
      if (reset) begin
         btn_phase = PH_IDLE;
         hold_ticks = '0;
         long_flagged = 1'b0;
         long_threshold = LONG_TICKS_RESET;
         head_ptr = 0;
         tail_ptr = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.event_valid = rsp_ch.event_valid;
            got.event_code = rsp_ch.event_code;
            got.pending = rsp_ch.pending;
            results_seen++;
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = expected_results.pop_front();
               if (got.event_valid !== want.event_valid)
                  note_mismatch($sformatf("result %0d event_valid %b, expected %b",
                                          results_seen, got.event_valid, want.event_valid));
               if (got.event_code !== want.event_code)
                  note_mismatch($sformatf("result %0d event_code %b, expected %b",
                                          results_seen, got.event_code, want.event_code));
               if (got.pending !== want.pending)
                  note_mismatch($sformatf("result %0d pending %b, expected %b",
                                          results_seen, got.pending, want.pending));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want = classify_step(req_ch.cmd, req_ch.button_down);
            if (row_pinned) want = row_result;
            expected_results.push_back(want);
         end
         if (csr_we) long_threshold = csr_wdata;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Result side: random stalls; no new stall starts while no_idle is set.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
         @(posedge clock);
      end
   end

   task automatic send_item(logic cmd, logic button, logic pinned, key_result_type want);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.button_down <= button;
      row_pinned <= pinned;
      row_result <= want;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
   endtask

   task automatic set_threshold(logic [TICKS_W-1:0] value);
      drain_results();
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_thr = int'(value);
   endtask

   // One scan tick, sometimes preceded by a pop of the oldest event.
   task automatic sample_button(logic level);
      if ($urandom_range(0, 99) < pop_pct)
         send_item(CMD_POP, 1'($urandom_range(0, 1)), 1'b0, '0);
      send_item(CMD_TICK, level, 1'b0, '0);
   endtask

   initial begin
      int r;
      int hold;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_TICK;
      req_ch.button_down <= 1'b0;
      row_pinned <= 1'b0;
      row_result <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      reset <= 1'b1;
      items_sent = 0;
      results_seen = 0;
      mismatch_count = 0;
      no_idle = 1'b0;
      pop_pct = 0;
      cur_thr = int'(LONG_TICKS_RESET);
      long_budget = 2;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED[i].kind == ROW_CFG)
            set_threshold(DIRECTED[i].value);
         else
            send_item(DIRECTED[i].cmd, DIRECTED[i].button, DIRECTED[i].pinned,
                      DIRECTED[i].want);
      end

      // Episodes of well-formed presses with bounce, pops and the odd burst of noise.
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 2) == 0) begin
            r = $urandom_range(0, 9);
            if (r < 4) set_threshold(TICKS_W'($urandom_range(0, 4)));
            else if (r < 7) set_threshold(TICKS_W'($urandom_range(5, 12)));
            else if (r < 9) set_threshold(TICKS_W'($urandom_range(13, 60)));
            else set_threshold(8'd255);
         end else if ($urandom_range(0, 5) == 0) begin
            drain_results();
         end
         no_idle = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0: pop_pct = 0;
            1: pop_pct = 8;
            2: pop_pct = 25;
            default: pop_pct = 50;
         endcase
         repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(4, 10))
                  send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
               repeat ($urandom_range(0, 2)) sample_button(1'b0);
               sample_button(1'b1);
               if ($urandom_range(0, 6) == 0) begin
                  sample_button(1'b0);
               end else begin
                  // Long presses at the top threshold cost hundreds of ticks, so few are run.
                  if (cur_thr > 60 && long_budget > 0 && $urandom_range(0, 1) == 1) begin
                     hold = cur_thr + $urandom_range(1, 4);
                     long_budget--;
                  end else if (cur_thr > 60) begin
                     hold = $urandom_range(0, 20);
                  end else begin
                     hold = $urandom_range(0, cur_thr + 4);
                  end
                  repeat (hold + 1) sample_button(1'b1);
                  if ($urandom_range(0, 3) == 0) begin
                     sample_button(1'b0);
                     repeat ($urandom_range(1, 4)) sample_button(1'b1);
                  end
                  sample_button(1'b0);
                  sample_button(1'b0);
               end
            end
         end
         // After a fill episode, empty the ring and pop past the end.
         if (pop_pct == 0)
            repeat (DEPTH) send_item(CMD_POP, 1'($urandom_range(0, 1)), 1'b0, '0);
      end

      drain_results();
      repeat (5) @(posedge clock);
      if (expected_results.size() != 0)
         note_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
      if (mismatch_count == 0) begin
         $display("key_press_classifier_fifo_unit test passed");
      end else begin
         $display("key_press_classifier_fifo_unit test failed");
      end
      $finish;
   end

endmodule
